// File: design/lps_pkg.sv
// Shared types and constants for the line pixel stepper.
package lps_pkg;

    localparam int unsigned X_W        = 9;
    localparam int unsigned Y_W        = 8;
    localparam int unsigned COLOR_W    = 16;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned DELTA_W    = 10;
    localparam int unsigned ERR_W      = 12;
    localparam int unsigned ROW_SHIFT  = 10;
    localparam int unsigned COL_SHIFT  = 1;
    localparam int unsigned LPS_QUEUE_DEPTH = 2;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    // One classified word handed from the front to the back.
    typedef struct packed {
        logic                      is_load;
        logic                      vertical;
        logic                      steep;
        logic [X_W-1:0]            major_pos;
        logic [X_W-1:0]            major_end;
        logic [X_W-1:0]            minor_pos;
        logic [X_W-1:0]            major_delta;
        logic signed [DELTA_W-1:0] minor_delta;
        logic [COLOR_W-1:0]        color;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: design/lps_front.sv
// Front end: accepts input words and turns a load into major/minor line setup.
module lps_front
    import lps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_mode,
    input  logic [X_W-1:0]     i_start_x,
    input  logic [Y_W-1:0]     i_start_y,
    input  logic [X_W-1:0]     i_end_x,
    input  logic [Y_W-1:0]     i_end_y,
    input  logic [COLOR_W-1:0] i_line_color,
    input  t_q_status          i_q_status,
    output logic               o_push,
    output t_cmd               o_cmd
);

    logic [DELTA_W-1:0] dx;
    logic [X_W-1:0]     adx;
    logic [Y_W:0]       dy;
    logic [Y_W-1:0]     ady;
    logic               steep;
    logic               vertical;
    logic [X_W-1:0]     a0, a1, b0, b1;
    logic               swap;
    logic [X_W-1:0]     y_hi, y_lo;
    logic               r_seen_reset;

    // Front keeps no line state; this flop only holds ready low in reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_reset <= 1'b0;
        end else begin
            r_seen_reset <= 1'b1;
        end
    end

    assign o_ready = r_seen_reset && !i_q_status.full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        dx    = {1'b0, i_end_x} - {1'b0, i_start_x};
        adx   = dx[DELTA_W-1] ? X_W'(-dx) : dx[X_W-1:0];
        dy    = {1'b0, i_end_y} - {1'b0, i_start_y};
        ady   = dy[Y_W] ? Y_W'(-dy) : dy[Y_W-1:0];
        steep = {1'b0, ady} > adx;
        vertical = (i_start_x == i_end_x);

        if (steep) begin
            a0 = {1'b0, i_start_y};
            a1 = {1'b0, i_end_y};
            b0 = i_start_x;
            b1 = i_end_x;
        end else begin
            a0 = i_start_x;
            a1 = i_end_x;
            b0 = {1'b0, i_start_y};
            b1 = {1'b0, i_end_y};
        end
        swap = a1 < a0;

        if (i_start_y > i_end_y) begin
            y_hi = {1'b0, i_start_y};
            y_lo = {1'b0, i_end_y};
        end else begin
            y_hi = {1'b0, i_end_y};
            y_lo = {1'b0, i_start_y};
        end

        o_cmd.is_load = (i_mode == MODE_LOAD);
        o_cmd.color   = i_line_color;
        if (vertical) begin
            // vertical (or single point): walk y from the larger end down
            o_cmd.vertical    = 1'b1;
            o_cmd.steep       = 1'b0;
            o_cmd.major_pos   = y_hi;
            o_cmd.major_end   = y_lo;
            o_cmd.minor_pos   = i_start_x;
            o_cmd.major_delta = '0;
            o_cmd.minor_delta = '0;
        end else begin
            o_cmd.vertical    = 1'b0;
            o_cmd.steep       = steep;
            o_cmd.major_pos   = swap ? a1 : a0;
            o_cmd.major_end   = swap ? a0 : a1;
            o_cmd.minor_pos   = swap ? b1 : b0;
            o_cmd.major_delta = swap ? (a0 - a1) : (a1 - a0);
            o_cmd.minor_delta = swap ? ({1'b0, b0} - {1'b0, b1})
                                     : ({1'b0, b1} - {1'b0, b0});
        end
    end

endmodule

// File: design/lps_queue.sv
// Short FIFO of classified words between the front and the back.
module lps_queue
    import lps_pkg::*;
#(
    parameter int unsigned DEPTH = LPS_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_valid        = !o_status.empty;
    assign o_cmd          = r_slot[r_rd_ptr];
    assign do_pop         = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/lps_back.sv
// Back end: holds the active line, steps the error term, drives the pixel register.
module lps_back
    import lps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    input  logic [ADDR_W-1:0]  i_base,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [X_W-1:0]     o_pixel_x,
    output logic [Y_W-1:0]     o_pixel_y,
    output logic [ADDR_W-1:0]  o_pixel_address,
    output logic [COLOR_W-1:0] o_pixel_color,
    output logic               o_last_pixel
);

    logic                      r_active, n_active;
    logic                      r_steep, n_steep;
    logic                      r_vert, n_vert;
    logic [X_W-1:0]            r_major_pos, n_major_pos;
    logic [X_W-1:0]            r_major_end, n_major_end;
    logic [X_W-1:0]            r_minor_pos, n_minor_pos;
    logic [X_W-1:0]            r_major_delta, n_major_delta;
    logic signed [DELTA_W-1:0] r_minor_delta, n_minor_delta;
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic [COLOR_W-1:0]        r_color, n_color;

    logic                      r_out_valid, n_out_valid;
    logic [X_W-1:0]            r_out_x;
    logic [Y_W-1:0]            r_out_y;
    logic [ADDR_W-1:0]         r_out_addr;
    logic [COLOR_W-1:0]        r_out_color;
    logic                      r_out_last;

    logic                      emit;
    logic [X_W-1:0]            px;
    logic [Y_W-1:0]            py;
    logic                      last;
    logic signed [ERR_W-1:0]   twice_minor, twice_major, err_sum;
    logic [ADDR_W-1:0]         pix_offset;

    // a request needs a free output slot; a load never waits
    assign o_pop = i_q_valid && (i_cmd.is_load || !r_out_valid || i_ready);
    assign emit  = o_pop && !i_cmd.is_load && r_active;

    always_comb begin
        px   = (r_vert || r_steep) ? r_minor_pos : r_major_pos;
        py   = (r_vert || r_steep) ? r_major_pos[Y_W-1:0] : r_minor_pos[Y_W-1:0];
        last = (r_major_pos == r_major_end);
        // row and column fields do not overlap, so one OR joins them
        pix_offset = (ADDR_W'(py) << ROW_SHIFT) | (ADDR_W'(px) << COL_SHIFT);

        twice_minor = {{(ERR_W-DELTA_W){r_minor_delta[DELTA_W-1]}}, r_minor_delta} <<< 1;
        twice_major = $signed({{(ERR_W-X_W){1'b0}}, r_major_delta}) <<< 1;
        err_sum     = r_err + twice_minor;

        n_active      = r_active;
        n_steep       = r_steep;
        n_vert        = r_vert;
        n_major_pos   = r_major_pos;
        n_major_end   = r_major_end;
        n_minor_pos   = r_minor_pos;
        n_major_delta = r_major_delta;
        n_minor_delta = r_minor_delta;
        n_err         = r_err;
        n_color       = r_color;

        if (o_pop && i_cmd.is_load) begin
            n_active      = 1'b1;
            n_steep       = i_cmd.steep;
            n_vert        = i_cmd.vertical;
            n_major_pos   = i_cmd.major_pos;
            n_major_end   = i_cmd.major_end;
            n_minor_pos   = i_cmd.minor_pos;
            n_major_delta = i_cmd.major_delta;
            n_minor_delta = i_cmd.minor_delta;
            n_err         = $signed({{(ERR_W-X_W){1'b0}}, i_cmd.major_delta});
            n_color       = i_cmd.color;
        end else if (emit) begin
            if (last) begin
                n_active = 1'b0;
            end else if (r_vert) begin
                n_major_pos = r_major_pos - 1'b1;
            end else begin
                n_major_pos = r_major_pos + 1'b1;
                if (err_sum >= twice_major) begin
                    n_err       = err_sum - twice_major;
                    n_minor_pos = r_minor_pos + 1'b1;
                end else if (err_sum < 0) begin
                    n_err       = err_sum + twice_major;
                    n_minor_pos = r_minor_pos - 1'b1;
                end else begin
                    n_err = err_sum;
                end
            end
        end

        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_steep       <= n_steep;
        r_vert        <= n_vert;
        r_major_pos   <= n_major_pos;
        r_major_end   <= n_major_end;
        r_minor_pos   <= n_minor_pos;
        r_major_delta <= n_major_delta;
        r_minor_delta <= n_minor_delta;
        r_err         <= n_err;
        r_color       <= n_color;
        if (emit) begin
            r_out_x     <= px;
            r_out_y     <= py;
            r_out_addr  <= i_base + pix_offset;
            r_out_color <= r_color;
            r_out_last  <= last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pixel_x       = r_out_x;
    assign o_pixel_y       = r_out_y;
    assign o_pixel_address = r_out_addr;
    assign o_pixel_color   = r_out_color;
    assign o_last_pixel    = r_out_last;

endmodule

// File: design/line_pixel_stepper.sv
// Top level of the line pixel stepper: front end, word queue, stepping back end.
//
//  channel  | handshake                   | word
//  ---------+-----------------------------+-----------------------------------------
//  input    | i_valid / o_ready           | mode, start/end x and y, line color
//  output   | o_valid / i_ready           | pixel x, y, address, color, last flag
//  config   | i_cfg_valid / o_cfg_ready   | buffer base address
//
// One word per clock is accepted while the queue is not full and one pixel per
// clock is produced while i_ready is high, via a queue slot and the pixel register.
// Reset (synchronous, active low) empties the queue and drops any active line.
// A stalled output holds its pixel; requests then back up in the queue and
// o_ready falls once the queue is full. A load at the head of the queue drains
// even while the output is stalled.
module line_pixel_stepper
    import lps_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = LPS_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_mode,
    input  logic [X_W-1:0]     i_start_x,
    input  logic [Y_W-1:0]     i_start_y,
    input  logic [X_W-1:0]     i_end_x,
    input  logic [Y_W-1:0]     i_end_y,
    input  logic [COLOR_W-1:0] i_line_color,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [X_W-1:0]     o_pixel_x,
    output logic [Y_W-1:0]     o_pixel_y,
    output logic [ADDR_W-1:0]  o_pixel_address,
    output logic [COLOR_W-1:0] o_pixel_color,
    output logic               o_last_pixel,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [ADDR_W-1:0]  i_buffer_base
);

    logic [ADDR_W-1:0] r_base;
    t_q_status         q_status;
    t_cmd              push_cmd;
    t_cmd              q_cmd;
    logic              q_push;
    logic              q_valid;
    logic              q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_valid) begin
            r_base <= i_buffer_base;
        end
    end

    lps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_line_color (i_line_color),
        .i_q_status   (q_status),
        .o_push       (q_push),
        .o_cmd        (push_cmd)
    );

    lps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_cmd    (push_cmd),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_cmd    (q_cmd),
        .o_status (q_status)
    );

    lps_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (q_pop),
        .i_base          (r_base),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last_pixel    (o_last_pixel)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !q_push)
        else $error("word pushed into a full queue");

    a_request_waits_for_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && !q_cmd.is_load) |-> (!o_valid || i_ready))
        else $error("request popped while pixel register held");

    a_pixel_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(q_pop))
        else $error("pixel appeared without a queue pop");

    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from an empty queue");

endmodule
